FILE: design/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types, widths, codes and helpers of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

   localparam int IDX_W = 10;
   localparam int CNT_W = 11;
   localparam int DEFAULT_POOL_BLOCKS = 1024;
   localparam int MAX_COUNT = 2047;

   localparam logic [CNT_W-1:0] ACTIVE_RESET = 11'd1024;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_BAD   = 2'd2;

   typedef struct packed {
      logic accept;
      logic link_load;
      logic cfg_write;
   } dp_cmd_type;

   typedef struct packed {
      logic needs_link;
   } dp_status_type;

   function automatic logic [CNT_W-1:0] clamp_active(input logic [CNT_W-1:0] value,
                                                     input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] result;
      if (value == '0) begin
         result = {{(CNT_W-1){1'b0}}, 1'b1};
      end else if (value > cap) begin
         result = cap;
      end else begin
         result = value;
      end
      return result;
   endfunction

endpackage

FILE: design/fbpa_ctrl.sv
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Controller: request acceptance, head update sequencing, response valid.
// ----------------------------------------------------------------------------
module fbpa_ctrl
   import fbpa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic          cfg_write,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LINK = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      dp_cmd.accept    = accept;
      dp_cmd.link_load = (state_ff == ST_LINK);
      dp_cmd.cfg_write = cfg_write;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && dp_status.needs_link) begin
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_link_after_alloc: assert property (@(posedge clock) disable iff (reset)
      accept && dp_status.needs_link |=> state_ff == ST_LINK)
      else $error("successful allocate did not start head update");

   a_link_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LINK |=> state_ff == ST_IDLE)
      else $error("head update lasted more than one cycle");

   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted transfer produced no response");

endmodule

FILE: design/fbpa_dp.sv
// ----------------------------------------------------------------------------
// fbpa_dp
// Datapath: link memory, head, counters, active size register, response.
// ----------------------------------------------------------------------------
module fbpa_dp
   import fbpa_pkg::*;
#(
   parameter int POOL_BLOCKS = DEFAULT_POOL_BLOCKS
)
(
   input  logic             clock,
   input  logic             reset,
   input  dp_cmd_type       dp_cmd,
   output dp_status_type    dp_status,
   input  logic             req_mode,
   input  logic [IDX_W-1:0] req_block_index,
   input  logic [CNT_W-1:0] cfg_wdata,
   output logic [CNT_W-1:0] active_blocks,
   output logic [IDX_W-1:0] rsp_granted_index,
   output logic [1:0]       rsp_status,
   output logic [CNT_W-1:0] rsp_free_count
);

   localparam int AW = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
   localparam int PoolCap = (POOL_BLOCKS > MAX_COUNT) ? MAX_COUNT : POOL_BLOCKS;
   localparam logic [CNT_W-1:0] CAP = CNT_W'(PoolCap);

   logic [CNT_W-1:0] link_mem [POOL_BLOCKS];

   logic [CNT_W-1:0] active_ff, active_in;
   logic [CNT_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] free_ff, free_in;
   logic [CNT_W-1:0] linked_ff, linked_in;
   logic             bypass_ff, bypass_in;
   logic [CNT_W-1:0] rdata_ff;
   logic [IDX_W-1:0] granted_ff, granted_in;
   logic [1:0]       status_ff, status_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [CNT_W-1:0] n;
   logic             alloc_ok, free_ok, lazy_link;
   logic             mem_we, mem_re;
   logic [AW-1:0]    mem_waddr, mem_raddr;
   logic [CNT_W-1:0] mem_wdata;

   assign n         = clamp_active(active_ff, CAP);
   assign alloc_ok  = (free_ff != '0) && (head_ff < n);
   assign free_ok   = ({1'b0, req_block_index} < n) && (free_ff < n);
   assign lazy_link = linked_ff < n;

   assign dp_status.needs_link = !req_mode && alloc_ok;

   always_comb begin
      active_in  = active_ff;
      head_in    = head_ff;
      free_in    = free_ff;
      linked_in  = linked_ff;
      bypass_in  = bypass_ff;
      granted_in = granted_ff;
      status_in  = status_ff;
      count_in   = count_ff;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_waddr  = AW'(linked_ff);
      mem_wdata  = linked_ff + 11'd1;
      mem_raddr  = AW'(head_ff);
      if (dp_cmd.cfg_write) begin
         active_in = cfg_wdata;
         head_in   = '0;
         linked_in = '0;
         free_in   = clamp_active(cfg_wdata, CAP);
      end else if (dp_cmd.link_load) begin
         head_in = bypass_ff ? linked_ff : rdata_ff;
      end else if (dp_cmd.accept) begin
         granted_in = '0;
         status_in  = STATUS_OK;
         if (!req_mode) begin
            if (alloc_ok) begin
               if (lazy_link) begin
                  mem_we    = 1'b1;
                  linked_in = linked_ff + 11'd1;
               end
               bypass_in  = lazy_link && (head_ff == linked_ff);
               mem_re     = 1'b1;
               granted_in = head_ff[IDX_W-1:0];
               free_in    = free_ff - 11'd1;
            end else begin
               status_in = STATUS_EMPTY;
            end
         end else begin
            if (free_ok) begin
               mem_we    = 1'b1;
               mem_waddr = AW'(req_block_index);
               mem_wdata = head_ff;
               head_in   = {1'b0, req_block_index};
               free_in   = free_ff + 11'd1;
            end else begin
               status_in = STATUS_BAD;
            end
         end
         count_in = free_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= link_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
         head_ff   <= '0;
         linked_ff <= '0;
         free_ff   <= clamp_active(ACTIVE_RESET, CAP);
         bypass_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         head_ff   <= head_in;
         linked_ff <= linked_in;
         free_ff   <= free_in;
         bypass_ff <= bypass_in;
      end
   end

   always_ff @(posedge clock) begin
      granted_ff <= granted_in;
      status_ff  <= status_in;
      count_ff   <= count_in;
   end

   assign active_blocks     = active_ff;
   assign rsp_granted_index = granted_ff;
   assign rsp_status        = status_ff;
   assign rsp_free_count    = count_ff;

   a_free_within_pool: assert property (@(posedge clock) disable iff (reset)
      free_ff <= n)
      else $error("free count exceeds active pool size");

   a_linked_within_pool: assert property (@(posedge clock) disable iff (reset)
      !dp_cmd.cfg_write |-> linked_ff <= n)
      else $error("linked count exceeds active pool size");

endmodule

FILE: design/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block pool allocator with a lazily built free list.
//
//   channel   direction  handshake          payload
//   req       in         tvalid / tready    tuser mode, tdata block_index
//   rsp       out        tvalid / tready    tdata granted_index, status, free_count
//   csr       in/out     psel / penable     active_blocks at byte address 0
//
// a successful allocate reads the head link from the synchronous link memory
// in the accept cycle and loads the new head in the next cycle; a free or a
// rejected request needs no head update
// a waiting response blocks new requests; a request may transfer in the
// cycle the previous response leaves
// reset clears control state; the link memory is not cleared, entries are
// read only after they have been written
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator
   import fbpa_pkg::*;
#(
   parameter int POOL_BLOCKS = DEFAULT_POOL_BLOCKS
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // block_index[9:0], zero[15:10]
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // granted_index[9:0], status[11:10], free_count[22:12]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   dp_cmd_type       dp_cmd;
   dp_status_type    dp_status;
   logic             cfg_write;
   logic [CNT_W-1:0] active_blocks;
   logic [IDX_W-1:0] granted_index;
   logic [1:0]       status;
   logic [CNT_W-1:0] free_count;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {21'd0, active_blocks};

   assign rsp_tdata = {1'b0, free_count, status, granted_index};

   fbpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cfg_write  (cfg_write),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd)
   );

   fbpa_dp #(
      .POOL_BLOCKS (POOL_BLOCKS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .dp_cmd            (dp_cmd),
      .dp_status         (dp_status),
      .req_mode          (req_tuser),
      .req_block_index   (req_tdata[IDX_W-1:0]),
      .cfg_wdata         (csr_pwdata[CNT_W-1:0]),
      .active_blocks     (active_blocks),
      .rsp_granted_index (granted_index),
      .rsp_status        (status),
      .rsp_free_count    (free_count)
   );

endmodule
